### hw/rtl/thermal_grid_upscale_quantize_macros.svh
`ifndef THERMAL_GRID_UPSCALE_QUANTIZE_MACROS_SVH
`define THERMAL_GRID_UPSCALE_QUANTIZE_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define TGU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tgu check failed");

// next-cycle implication
`define TGU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tgu check failed");

`endif

### hw/rtl/tgu_pkg.sv
`default_nettype none

package tgu_pkg;

   // input item
   typedef struct packed {
      logic               operation;
      logic [5:0]         sample_index;
      logic signed [11:0] sample_value;
      logic [3:0]         render_column;
   } req_type;

   // result item
   typedef struct packed {
      logic [3:0]  pixel_row;
      logic [3:0]  pixel_column;
      logic [2:0]  level;
      logic [15:0] pattern;
      logic        last_pixel;
   } rsp_type;

   // settings seen by the render sequencer
   typedef struct packed {
      logic [6:0]       floor_degrees;
      logic [4:0][15:0] pattern;
   } cfg_type;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_FLOOR         = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CEILING       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_ZERO  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_ONE   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_TWO   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_THREE = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PATTERN_FOUR  = 3'd6;

   localparam logic [6:0] FLOOR_RESET   = 7'd20;
   localparam logic [6:0] CEILING_RESET = 7'd24;
   localparam logic [4:0][15:0] PATTERN_RESET =
      {16'hffff, 16'h7ebd, 16'h1428, 16'h1080, 16'h0000};

   localparam logic [2:0] LEVEL_MAX = 3'd4;

   localparam logic ALU_ADD = 1'b0;
   localparam logic ALU_SUB = 1'b1;

   // remainder of a 6-bit value by a constant modulus, by compare and subtract
   function automatic logic [5:0] wrap_value(input logic [5:0] v, input int unsigned m);
      logic [5:0]  r;
      int unsigned trial;
      r = v;
      for (int s = 5; s >= 0; s--) begin
         trial = m << s;
         if (32'(r) >= trial) begin
            r = r - 6'(trial);
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/tgu_frame_ram.sv
`default_nettype none

module tgu_frame_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 12
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/tgu_alu.sv
`default_nettype none

module tgu_alu #(
   parameter int WIDTH = 16
) (
   input  wire logic                    op,
   input  wire logic signed [WIDTH-1:0] a,
   input  wire logic signed [WIDTH-1:0] b,
   output      logic signed [WIDTH-1:0] result
);

   import tgu_pkg::*;

   always_comb begin
      case (op)
         ALU_ADD: result = a + b;
         ALU_SUB: result = a - b;
         default: result = a - b;
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/tgu_render.sv
`default_nettype none
`include "thermal_grid_upscale_quantize_macros.svh"

module tgu_render #(
   parameter int GRID_SIDE    = 8,
   parameter int SAMPLE_WIDTH = 12,
   parameter int MAX_WIDTH    = 12,
   parameter int ALU_WIDTH    = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 go,
   input  wire logic [$clog2(2*GRID_SIDE)-1:0]       go_column,
   input  wire tgu_pkg::cfg_type                     cfg,
   input  wire logic signed [MAX_WIDTH-1:0]          run_max,
   output      logic [$clog2(GRID_SIDE*GRID_SIDE)-1:0] rd_addr,
   input  wire logic [SAMPLE_WIDTH-1:0]              rd_data,
   output      logic                                 alu_op,
   output      logic signed [ALU_WIDTH-1:0]          alu_a,
   output      logic signed [ALU_WIDTH-1:0]          alu_b,
   input  wire logic signed [ALU_WIDTH-1:0]          alu_result,
   output      logic                                 busy,
   output      logic                                 rsp_strobe,
   output      tgu_pkg::rsp_type                     rsp_data
);

   import tgu_pkg::*;

   localparam int OUT_SIDE = 2 * GRID_SIDE;
   localparam int CW       = $clog2(OUT_SIDE);
   localparam int GW       = $clog2(GRID_SIDE);
   localparam int IDX_W    = $clog2(GRID_SIDE * GRID_SIDE);
   localparam int AW       = ALU_WIDTH;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RANGE  = 3'd1;
   localparam logic [2:0] S_READ_A = 3'd2;
   localparam logic [2:0] S_READ_B = 3'd3;
   localparam logic [2:0] S_SUM    = 3'd4;
   localparam logic [2:0] S_DIFF   = 3'd5;
   localparam logic [2:0] S_DIV    = 3'd6;

   logic [2:0]                  state_ff, state_in;
   logic [CW-1:0]               col_ff, col_in;
   logic [CW-1:0]               row_ff, row_in;
   logic signed [AW-1:0]        range_ff, range_in;
   logic [SAMPLE_WIDTH-1:0]     a_ff, a_in;
   logic signed [AW-1:0]        sum_ff, sum_in;
   logic signed [AW-1:0]        rem_ff, rem_in;
   logic [2:0]                  cnt_ff, cnt_in;
   rsp_type                     rsp_ff, rsp_in;
   logic                        rsp_strobe_ff, rsp_strobe_in;

   logic [GW-1:0]               c, r, c_nb, r_nb;
   logic                        c_last, r_last, row_last;
   logic [IDX_W-1:0]            addr_a, addr_b;
   logic signed [AW-1:0]        mx_ext, fl_ext, deg, a_ext, b_ext;
   logic                        emit;
   logic [2:0]                  emit_level;

   // neighbour addressing, clamped at the far edge
   assign c        = col_ff[CW-1:1];
   assign r        = row_ff[CW-1:1];
   assign c_last   = (c == GW'(GRID_SIDE - 1));
   assign r_last   = (r == GW'(GRID_SIDE - 1));
   assign row_last = (row_ff == CW'(OUT_SIDE - 1));
   assign c_nb     = (col_ff[0] && !c_last) ? c + GW'(1) : c;
   assign r_nb     = (!col_ff[0] && row_ff[0] && !r_last) ? r + GW'(1) : r;
   assign addr_a   = IDX_W'(c) * IDX_W'(GRID_SIDE) + IDX_W'(r);
   assign addr_b   = IDX_W'(c_nb) * IDX_W'(GRID_SIDE) + IDX_W'(r_nb);

   assign mx_ext = $signed({{(AW-MAX_WIDTH){run_max[MAX_WIDTH-1]}}, run_max}) >>> 2;
   assign fl_ext = $signed({{(AW-7){1'b0}}, cfg.floor_degrees});
   assign deg    = sum_ff >>> 3;
   assign a_ext  = $signed({{(AW-SAMPLE_WIDTH){a_ff[SAMPLE_WIDTH-1]}}, a_ff});
   assign b_ext  = $signed({{(AW-SAMPLE_WIDTH){rd_data[SAMPLE_WIDTH-1]}}, rd_data});

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      range_in      = range_ff;
      a_in          = a_ff;
      sum_in        = sum_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      rd_addr       = addr_a;
      alu_op        = ALU_SUB;
      alu_a         = '0;
      alu_b         = '0;
      emit          = 1'b0;
      emit_level    = '0;

      case (state_ff)
         S_IDLE: begin
            if (go) begin
               col_in   = go_column;
               row_in   = '0;
               state_in = S_RANGE;
            end
         end
         S_RANGE: begin
            alu_a = mx_ext;
            alu_b = fl_ext;
            if (alu_result <= 0) begin
               range_in = AW'(1);
            end else begin
               range_in = alu_result;
            end
            state_in = S_READ_A;
         end
         S_READ_A: begin
            rd_addr  = addr_a;
            state_in = S_READ_B;
         end
         S_READ_B: begin
            rd_addr  = addr_b;
            a_in     = rd_data;
            state_in = S_SUM;
         end
         S_SUM: begin
            alu_op   = ALU_ADD;
            alu_a    = a_ext;
            alu_b    = b_ext;
            sum_in   = alu_result;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            alu_a = deg;
            alu_b = fl_ext;
            if (alu_result <= 0) begin
               emit = 1'b1;
            end else begin
               rem_in   = alu_result <<< 2;
               cnt_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            alu_a = rem_ff;
            alu_b = range_ff;
            if (alu_result >= 0) begin
               rem_in = alu_result;
               cnt_in = cnt_ff + 3'd1;
               if (cnt_ff + 3'd1 == LEVEL_MAX) begin
                  emit       = 1'b1;
                  emit_level = LEVEL_MAX;
               end
            end else begin
               emit       = 1'b1;
               emit_level = cnt_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         rsp_in.pixel_row    = 4'(row_ff);
         rsp_in.pixel_column = 4'(col_ff);
         rsp_in.level        = emit_level;
         rsp_in.pattern      = cfg.pattern[emit_level];
         rsp_in.last_pixel   = row_last;
         rsp_strobe_in       = 1'b1;
         if (row_last) begin
            state_in = S_IDLE;
         end else begin
            row_in   = row_ff + CW'(1);
            state_in = S_READ_A;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff   <= col_in;
      row_ff   <= row_in;
      range_ff <= range_in;
      a_ff     <= a_in;
      sum_ff   <= sum_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `TGU_ASSERT_NEXT(a_go_enters_range, clock, reset, go && state_ff == S_IDLE, state_ff == S_RANGE)
   `TGU_ASSERT_NOW(a_level_bounded, clock, reset, rsp_strobe_ff, rsp_ff.level <= LEVEL_MAX)
   `TGU_ASSERT_NOW(a_last_ends_render, clock, reset, rsp_strobe_ff && rsp_ff.last_pixel, state_ff == S_IDLE)
   `TGU_ASSERT_NEXT(a_pixels_spaced, clock, reset, rsp_strobe_ff, !rsp_strobe_ff)
   `TGU_ASSERT_NOW(a_div_range_positive, clock, reset, state_ff == S_DIV, range_ff > 0 && cnt_ff < LEVEL_MAX)

endmodule

`default_nettype wire

### hw/rtl/thermal_grid_upscale_quantize.sv
`default_nettype none

// thermal frame upscaler and level quantizer. a load transfer (operation 0) writes one
// quarter-degree sample into the frame store and raises the running maximum; busy stays low,
// so loads may come every cycle while no render runs. a render transfer (operation 1)
// names one column of the 2x grid; busy then stays high while one subtract finds the range
// and, per pixel, two reads on the frame store's one read port, one add, one subtract and up
// to four compare-subtract steps of the shared alu find the level. pixels come out row 0
// first, each on rsp_data for exactly one cycle with rsp_strobe high; the receiver
// cannot stall them and must take every one. last_pixel marks the final row.
// rendering a cell never loaded since reset gives an unspecified level. configuration
// writes belong in idle time only; writing the ceiling also reloads the running maximum.
module thermal_grid_upscale_quantize #(
   parameter int GRID_SIDE    = 8,
   parameter int SAMPLE_WIDTH = 12
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire tgu_pkg::req_type                  req_data,
   output      logic                              rsp_strobe,
   output      tgu_pkg::rsp_type                  rsp_data,
   input  wire logic                              csr_we,
   input  wire logic [tgu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [tgu_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import tgu_pkg::*;

   localparam int CELLS     = GRID_SIDE * GRID_SIDE;
   localparam int OUT_SIDE  = 2 * GRID_SIDE;
   localparam int IDX_W     = $clog2(CELLS);
   localparam int CW        = $clog2(OUT_SIDE);
   // running maximum must hold both a sample and ceiling*4
   localparam int MAX_WIDTH = (SAMPLE_WIDTH > 10) ? SAMPLE_WIDTH : 10;
   // room for a sum of two samples and four times a degree difference
   localparam int ALU_WIDTH = MAX_WIDTH + 4;

   // configuration and running maximum
   logic [6:0]                    floor_ff, floor_in;
   logic [4:0][15:0]              pattern_ff, pattern_in;
   logic signed [MAX_WIDTH-1:0]   max_ff, max_in;
   cfg_type                       cfg;

   // transfer decode
   logic                          accept;
   logic                          load_go;
   logic                          render_go;
   logic [IDX_W-1:0]              load_addr;
   logic [SAMPLE_WIDTH-1:0]       load_value;
   logic signed [MAX_WIDTH-1:0]   load_value_ext;
   logic [CW-1:0]                 render_col;

   // frame store read port and shared alu
   logic [IDX_W-1:0]              rd_addr;
   logic [SAMPLE_WIDTH-1:0]       rd_data;
   logic                          alu_op;
   logic signed [ALU_WIDTH-1:0]   alu_a, alu_b, alu_result;

   assign accept    = start && !busy;
   assign load_go   = accept && (req_data.operation == OP_LOAD);
   assign render_go = accept && (req_data.operation == OP_RENDER);

   // out-of-range indexes wrap around the store and the output width
   assign load_addr  = IDX_W'(wrap_value(req_data.sample_index, CELLS));
   assign render_col = CW'(wrap_value({2'b00, req_data.render_column}, OUT_SIDE));

   // sample field is taken as SAMPLE_WIDTH bits, sign at the top of that width
   assign load_value     = SAMPLE_WIDTH'($unsigned(req_data.sample_value));
   assign load_value_ext = MAX_WIDTH'($signed(load_value));

   always_comb begin
      floor_in   = floor_ff;
      pattern_in = pattern_ff;
      max_in     = max_ff;

      // running maximum only grows on loads
      if (load_go && (load_value_ext > max_ff)) begin
         max_in = load_value_ext;
      end

      if (csr_we) begin
         case (csr_index)
            REG_FLOOR:         floor_in      = csr_wdata[6:0];
            REG_CEILING:       max_in        = MAX_WIDTH'({csr_wdata[6:0], 2'b00});
            REG_PATTERN_ZERO:  pattern_in[0] = csr_wdata;
            REG_PATTERN_ONE:   pattern_in[1] = csr_wdata;
            REG_PATTERN_TWO:   pattern_in[2] = csr_wdata;
            REG_PATTERN_THREE: pattern_in[3] = csr_wdata;
            REG_PATTERN_FOUR:  pattern_in[4] = csr_wdata;
            default:           floor_in      = floor_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff   <= FLOOR_RESET;
         pattern_ff <= PATTERN_RESET;
         max_ff     <= MAX_WIDTH'({CEILING_RESET, 2'b00});
      end else begin
         floor_ff   <= floor_in;
         pattern_ff <= pattern_in;
         max_ff     <= max_in;
      end
   end

   assign cfg.floor_degrees = floor_ff;
   assign cfg.pattern       = pattern_ff;

   // frame store: written by load transfers, read by the render sequencer
   tgu_frame_ram #(
      .DEPTH (CELLS),
      .WIDTH (SAMPLE_WIDTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (load_go),
      .wr_addr (load_addr),
      .wr_data (load_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // one add/subtract unit serves range, sum, difference and level steps
   tgu_alu #(
      .WIDTH (ALU_WIDTH)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_result)
   );

   // per-pixel sequencer, owns the result register
   tgu_render #(
      .GRID_SIDE    (GRID_SIDE),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .MAX_WIDTH    (MAX_WIDTH),
      .ALU_WIDTH    (ALU_WIDTH)
   ) u_render (
      .clock      (clock),
      .reset      (reset),
      .go         (render_go),
      .go_column  (render_col),
      .cfg        (cfg),
      .run_max    (max_ff),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .alu_op     (alu_op),
      .alu_a      (alu_a),
      .alu_b      (alu_b),
      .alu_result (alu_result),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

### tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tgu_pkg::*;

   localparam int GRID        = 8;
   localparam int OUT_SIDE    = 2 * GRID;
   localparam int TAIL_CYCLES = 140;     // longest render plus margin
   localparam int CYCLE_LIMIT = 500000;
   localparam int REPORT_MAX  = 10;

   // dut ports; the ones driven here are known from time zero
   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   start     = 1'b0;
   logic                   busy;
   req_type                req_data  = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // mirror of the block state: settings, frame in quarter degrees, running peak
   logic [6:0]       floor_deg     = FLOOR_RESET;
   logic [6:0]       ceil_deg      = CEILING_RESET;
   logic [4:0][15:0] level_pattern = PATTERN_RESET;
   int               peak_qd       = int'(CEILING_RESET) * 4;
   int               frame_qd [GRID*GRID];

   // items waiting to go out, pixels waiting to come back
   req_type pend_q  [$];
   rsp_type pixel_q [$];

   int   send_idle_pct = 7;
   int   fault_count   = 0;
   int   cycle_count   = 0;
   logic req_taken     = 1'b0;

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   thermal_grid_upscale_quantize #(
      .GRID_SIDE    (GRID),
      .SAMPLE_WIDTH (12)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // load item; the unused column field gets random bits
   function automatic req_type load_item(input int slot, input int value_qd);
      req_type it;
      it.operation     = OP_LOAD;
      it.sample_index  = 6'(slot);
      it.sample_value  = 12'(value_qd);
      it.render_column = 4'($urandom_range(15));
      return it;
   endfunction

   // render item; the unused sample fields get random bits
   function automatic req_type render_item(input int col);
      req_type it;
      it.operation     = OP_RENDER;
      it.sample_index  = 6'($urandom_range(63));
      it.sample_value  = 12'($urandom_range(4095));
      it.render_column = 4'(col);
      return it;
   endfunction

   // sample value: mostly around the current scale so levels spread out,
   // sometimes deep negative, rarely anywhere in the 12-bit range
   function automatic int scale_value();
      int lo, hi, pick;
      lo   = ((floor_deg < ceil_deg) ? int'(floor_deg) : int'(ceil_deg)) * 4 - 40;
      hi   = ((floor_deg > ceil_deg) ? int'(floor_deg) : int'(ceil_deg)) * 4 + 40;
      pick = $urandom_range(99);
      if (pick < 3) return int'($signed(12'($urandom_range(4095))));
      if (pick < 8) return -int'($urandom_range(2048));
      return lo + int'($urandom_range(hi - lo));
   endfunction

   task automatic note_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_MAX) $display("%s", what);
   endtask

   // one register write, mirrored in the model at once since the block is idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_FLOOR: begin
            floor_deg = val[6:0];
         end
         REG_CEILING: begin
            ceil_deg = val[6:0];
            peak_qd  = int'(val[6:0]) * 4;   // ceiling write reloads the running peak
         end
         default: begin
            level_pattern[idx - REG_PATTERN_ZERO] = val;
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // sender stops until every queued item is taken and every pixel is back
   task automatic settle(input int tail);
      do @(posedge clock); while (pend_q.size() != 0 || start);
      while (pixel_q.size() != 0 || busy) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   // random traffic: column refresh bursts (load a column group, render both
   // of its output columns) mixed with single loads and renders
   task automatic queue_random_items(input int n);
      int added, pick, grp;
      added = 0;
      while (added < n) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            grp = $urandom_range(GRID - 1);
            for (int r = 0; r < GRID; r++) begin
               pend_q.push_back(load_item(grp * GRID + r, scale_value()));
            end
            pend_q.push_back(render_item(2 * grp));
            pend_q.push_back(render_item(2 * grp + 1));
            added += GRID + 2;
         end else if (pick < 65) begin
            pend_q.push_back(load_item($urandom_range(GRID * GRID - 1), scale_value()));
            added++;
         end else begin
            pend_q.push_back(render_item($urandom_range(OUT_SIDE - 1)));
            added++;
         end
      end
   endtask

   // driver: inputs move on the falling edge; an item stays up until taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= pend_q.pop_front();
            start    <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: checks pixels and predicts from each accepted transfer
   always @(posedge clock) begin : monitor
      rsp_type want;
      int      col, gc, gr, gc2, gr2, deg, lvl, span, slot;
      if (reset) begin
         req_taken <= 1'b0;
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         cycle_count <= cycle_count + 1;
         req_taken   <= start && !busy;

         // pixels cannot be held off, so every strobe is a transfer
         if (rsp_strobe) begin
            if (pixel_q.size() == 0) begin
               note_fault($sformatf("unexpected pixel: row %0d col %0d level %0d",
                  rsp_data.pixel_row, rsp_data.pixel_column, rsp_data.level));
            end else begin
               want = pixel_q.pop_front();
               if (rsp_data.pixel_row !== want.pixel_row ||
                   rsp_data.pixel_column !== want.pixel_column ||
                   rsp_data.level !== want.level ||
                   rsp_data.pattern !== want.pattern ||
                   rsp_data.last_pixel !== want.last_pixel) begin
                  note_fault($sformatf({"pixel mismatch: expected row %0d col %0d level %0d ",
                     "pattern %h last %b, got row %0d col %0d level %0d pattern %h last %b"},
                     want.pixel_row, want.pixel_column, want.level, want.pattern,
                     want.last_pixel, rsp_data.pixel_row, rsp_data.pixel_column,
                     rsp_data.level, rsp_data.pattern, rsp_data.last_pixel));
               end
            end
         end

         if (start && !busy) begin
            if (req_data.operation == OP_LOAD) begin
               slot           = int'(req_data.sample_index);
               frame_qd[slot] = $signed(req_data.sample_value);
               if (frame_qd[slot] > peak_qd) peak_qd = frame_qd[slot];
            end else begin
               col = int'(req_data.render_column);
               // whole-degree span from floor to peak, at least one
               span = (peak_qd >>> 2) - int'(floor_deg);
               if (span <= 0) span = 1;
               for (int row = 0; row < OUT_SIDE; row++) begin
                  gc  = col / 2;
                  gr  = row / 2;
                  // neighbours past the last sample fall back to the last one
                  gc2 = (gc + 1 < GRID) ? gc + 1 : GRID - 1;
                  gr2 = (gr + 1 < GRID) ? gr + 1 : GRID - 1;
                  // arithmetic shifts give floor division for negative sums
                  if (col % 2 == 0 && row % 2 == 0) begin
                     deg = frame_qd[gc * GRID + gr] >>> 2;
                  end else if (col % 2 == 0) begin
                     deg = (frame_qd[gc * GRID + gr] + frame_qd[gc * GRID + gr2]) >>> 3;
                  end else begin
                     deg = (frame_qd[gc * GRID + gr] + frame_qd[gc2 * GRID + gr]) >>> 3;
                  end
                  if (deg <= int'(floor_deg)) begin
                     lvl = 0;
                  end else begin
                     lvl = (deg - int'(floor_deg)) * int'(LEVEL_MAX) / span;
                     if (lvl > int'(LEVEL_MAX)) lvl = int'(LEVEL_MAX);
                  end
                  want.pixel_row    = 4'(row);
                  want.pixel_column = 4'(col);
                  want.level        = 3'(lvl);
                  want.pattern      = level_pattern[lvl];
                  want.last_pixel   = (row == OUT_SIDE - 1);
                  pixel_q.push_back(want);
               end
            end
         end
      end
   end

   // stimulus: reset, directed edges, then three settings phases
   initial begin : stimulus
      int               low_group  [GRID] = '{-2048, 2047, -1, 0, 80, 83, 84, -5};
      int               high_group [GRID] = '{96, 100, 104, 2000, 79, 81, 7, -3};
      int               order [$];
      int               k, j, tmp, fl, cl;
      logic [4:0][15:0] words;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed, reset settings: value extremes in the first column group,
      // render its even column (vertical means, bottom row clamped)
      for (k = 0; k < GRID; k++) pend_q.push_back(load_item(k, low_group[k]));
      pend_q.push_back(render_item(0));
      // last column group: render both its columns; the rightmost clamps the horizontal neighbour
      for (k = 0; k < GRID; k++) pend_q.push_back(load_item(56 + k, high_group[k]));
      pend_q.push_back(render_item(14));
      pend_q.push_back(render_item(15));
      settle(TAIL_CYCLES);

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               fl = 0;
               cl = 127;
               send_idle_pct = 7;
            end
            1: begin
               // floor above the peak: span below one until loads lift it
               fl = 100;
               cl = 1;
               send_idle_pct = 83;
            end
            default: begin
               fl = $urandom_range(100);
               cl = $urandom_range(127, 1);
               send_idle_pct = 0;
            end
         endcase
         for (k = 0; k < 5; k++) begin
            if (ph == 1) words[k] = (k % 2 != 0) ? 16'hffff : 16'h0000;
            else words[k] = 16'($urandom);
         end
         for (k = 0; k < 5; k++) begin
            write_reg(CSR_INDEX_W'(int'(REG_PATTERN_ZERO) + k), words[k]);
         end
         write_reg(REG_FLOOR, 16'(fl));
         write_reg(REG_CEILING, 16'(cl));

         // fill the untouched middle of the frame in shuffled order so any
         // later render reads only loaded samples
         if (ph == 0) begin
            for (k = GRID; k < 56; k++) order.push_back(k);
            for (k = order.size() - 1; k > 0; k--) begin
               j        = $urandom_range(k);
               tmp      = order[k];
               order[k] = order[j];
               order[j] = tmp;
            end
            for (k = 0; k < order.size(); k++) begin
               pend_q.push_back(load_item(order[k], scale_value()));
            end
         end

         // halfway the sender holds off until every pixel is back
         queue_random_items(72);
         settle(TAIL_CYCLES);
         queue_random_items(72);
         settle(TAIL_CYCLES);
      end

      if (fault_count == 0 && pixel_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### thermal_grid_upscale_quantize.f
+incdir+hw/rtl
hw/rtl/tgu_pkg.sv
hw/rtl/tgu_frame_ram.sv
hw/rtl/tgu_alu.sv
hw/rtl/tgu_render.sv
hw/rtl/thermal_grid_upscale_quantize.sv
tb/tb.sv
